@@ rtl/ssm_pkg.sv @@
// Shared types and codes of the sorted sequence merge block.
package ssm_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef enum logic [1:0] {
    ACT_FIRST  = 2'd0,
    ACT_SECOND = 2'd1,
    ACT_MERGE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PICK,
    ST_HOLD
  } state_e;

  typedef struct packed {
    action_e                       action;
    logic signed [ValueWidth-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  merged_value;
    logic                          last;
  } out_t;

  typedef struct packed {
    logic take_first;
    logic last;
  } pick_t;

endpackage

@@ rtl/sorted_sequence_merge_top.sv @@
// Top level of the sorted sequence merge block: stores, sequencer, output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (action, value)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (merged_value, last)
//
// An append item leaves the block in idle, so it is ready again for the next item.
// A merge first reads the heads from the RAMs (FETCH), then for each result
// compares them (PICK) and holds the result in the output register (HOLD) until
// the consumer takes it; an empty merge emits nothing and leaves the block idle.
// The block takes no new item until the last result of a merge is delivered.
// Reset clears the counts and the sequencer; the stores are not cleared.
module sorted_sequence_merge_top import ssm_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0] cnt_a_q, cnt_b_q;   // fill counts
  logic [CW-1:0] idx_a_q, idx_b_q;   // merge read positions
  out_t          out_q;

  logic signed [ValueWidth-1:0] head_a, head_b;
  pick_t pick;

  logic in_fire, out_fire;
  logic wr_a, wr_b;
  logic cnt_total_zero;

  assign in_fire        = in_valid_i && in_ready_o;
  assign out_fire       = out_valid_o && out_ready_i;
  assign cnt_total_zero = (cnt_a_q == '0) && (cnt_b_q == '0);

  // Append writes; a full sequence drops the item.
  assign wr_a = in_fire && (in_data_i.action == ACT_FIRST)  && (cnt_a_q < CW'(DEPTH));
  assign wr_b = in_fire && (in_data_i.action == ACT_SECOND) && (cnt_b_q < CW'(DEPTH));

  ssm_ram #(.WIDTH(ValueWidth), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (idx_a_q[AW-1:0]),
    .rdata_o (head_a)
  );

  ssm_ram #(.WIDTH(ValueWidth), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (idx_b_q[AW-1:0]),
    .rdata_o (head_b)
  );

  ssm_pick #(.CW(CW)) u_pick (
    .head_a_i (head_a),
    .head_b_i (head_b),
    .idx_a_i  (idx_a_q),
    .idx_b_i  (idx_b_q),
    .cnt_a_i  (cnt_a_q),
    .cnt_b_i  (cnt_b_q),
    .pick_o   (pick)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        // start a merge only when something is stored
        if (in_fire && (in_data_i.action == ACT_MERGE) && !cnt_total_zero) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_PICK;
      ST_PICK:  state_d = ST_HOLD;
      ST_HOLD: begin
        if (out_ready_i) begin
          state_d = out_q.last ? ST_IDLE : ST_PICK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_HOLD:  out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      idx_a_q <= '0;
      idx_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_a) begin
        cnt_a_q <= cnt_a_q + CW'(1);
      end
      if (wr_b) begin
        cnt_b_q <= cnt_b_q + CW'(1);
      end
      // advance the read position of the taken head
      if (state_q == ST_PICK) begin
        if (pick.take_first) begin
          idx_a_q <= idx_a_q + CW'(1);
        end else begin
          idx_b_q <= idx_b_q + CW'(1);
        end
      end
      // final result delivered: empty both sequences
      if (out_fire && out_q.last) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        idx_a_q <= '0;
        idx_b_q <= '0;
      end
    end
  end

  // Output register; loaded once per result, held while stalled.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PICK) begin
      out_q.merged_value <= pick.take_first ? head_a : head_b;
      out_q.last         <= pick.last;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/ssm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ssm_pick.sv @@
// Head compare and select unit shared by every step of a merge.
module ssm_pick import ssm_pkg::*; #(
  parameter int unsigned CW = 6
) (
  input  logic signed [ValueWidth-1:0] head_a_i,
  input  logic signed [ValueWidth-1:0] head_b_i,
  input  logic        [CW-1:0]         idx_a_i,
  input  logic        [CW-1:0]         idx_b_i,
  input  logic        [CW-1:0]         cnt_a_i,
  input  logic        [CW-1:0]         cnt_b_i,
  output pick_t                        pick_o
);

  logic avail_a;
  logic avail_b;
  logic [CW-1:0] idx_a_inc;
  logic [CW-1:0] idx_b_inc;

  assign avail_a   = idx_a_i < cnt_a_i;
  assign avail_b   = idx_b_i < cnt_b_i;
  assign idx_a_inc = idx_a_i + CW'(1);
  assign idx_b_inc = idx_b_i + CW'(1);

  always_comb begin
    // first head wins only when strictly smaller; ties go to the second
    pick_o.take_first = avail_a && (!avail_b || (head_a_i < head_b_i));
    if (pick_o.take_first) begin
      pick_o.last = (idx_a_inc == cnt_a_i) && (idx_b_i == cnt_b_i);
    end else begin
      pick_o.last = (idx_a_i == cnt_a_i) && (idx_b_inc == cnt_b_i);
    end
  end

endmodule

@@ rtl/ssm_checker.sv @@
// Port-level checker of the sorted sequence merge block and its bind.
module ssm_checker import ssm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  // take no item while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result waits");

  // return to ready after the final result
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last) |=> in_ready_o)
    else $error("not ready after final result");

  // an append leaves the block ready and emits nothing
  a_append_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.action != ACT_MERGE))
      |=> (in_ready_o && !out_valid_o))
    else $error("append did not complete in one cycle");

endmodule

bind sorted_sequence_merge_top ssm_checker u_ssm_checker (.*);

@@ tb/sv/sorted_merge_checker.sv @@
// Checker for the sorted sequence merge block: tracks both sequences and compares merged runs.
module sorted_merge_checker import ssm_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [ValueWidth-1:0] first_seq  [DEPTH];
  logic signed [ValueWidth-1:0] second_seq [DEPTH];
  int unsigned first_len;
  int unsigned second_len;
  out_t        merged_expect_q [$];
  int          mismatches;
  int          result_idx;

  task automatic report_mismatch(input string what, input logic [ValueWidth-1:0] got,
                                 input logic [ValueWidth-1:0] want);
    $display("%0t ns: result %0d %s: got %0h, expected %0h", $time, result_idx, what, got, want);
    mismatches++;
  endtask

  // Two-way merge; ties take the second sequence's head.
  task automatic predict_merge();
    int unsigned i;
    int unsigned j;
    int unsigned total;
    out_t        res;
    i     = 0;
    j     = 0;
    total = first_len + second_len;
    while (i < first_len || j < second_len) begin
      if (i < first_len && j < second_len && first_seq[i] < second_seq[j]) begin
        res.merged_value = first_seq[i];
        i++;
      end else if (j < second_len) begin
        res.merged_value = second_seq[j];
        j++;
      end else begin
        res.merged_value = first_seq[i];
        i++;
      end
      res.last = (i + j == total);
      merged_expect_q.push_back(res);
    end
    first_len  = 0;
    second_len = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len  = 0;
      second_len = 0;
      mismatches = 0;
      result_idx = 0;
      merged_expect_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (merged_expect_q.size() == 0) begin
          report_mismatch("unexpected", out_data_i.merged_value, '0);
        end else begin
          if (out_data_i.merged_value !== merged_expect_q[0].merged_value) begin
            report_mismatch("merged_value", out_data_i.merged_value,
                            merged_expect_q[0].merged_value);
          end
          if (out_data_i.last !== merged_expect_q[0].last) begin
            report_mismatch("last", ValueWidth'(out_data_i.last),
                            ValueWidth'(merged_expect_q[0].last));
          end
          void'(merged_expect_q.pop_front());
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.action)
          ACT_FIRST: begin
            if (first_len < DEPTH) begin
              first_seq[first_len] = in_data_i.value;
              first_len++;
            end
          end
          ACT_SECOND: begin
            if (second_len < DEPTH) begin
              second_seq[second_len] = in_data_i.value;
              second_len++;
            end
          end
          ACT_MERGE: predict_merge();
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= merged_expect_q.size();
  end

endmodule

@@ tb/sv/tb_sorted_sequence_merge_top.sv @@
// Testbench top for the sorted sequence merge block: stimulus, idling phases and verdict.
module tb_sorted_sequence_merge_top import ssm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 32;
  localparam int          RandomItems = 420;
  localparam int          CycleLimit  = 1000000;
  localparam int          DrainCycles = 40;
  // Code 3 is not an action; the block must ignore it.
  localparam action_e     ACT_UNUSED  = action_e'(2'd3);

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int fail_count;
  int pending;
  int cycles        = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  sorted_sequence_merge_top #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  sorted_merge_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result channel at random; the phase sets how often.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item: idle first at the phase's rate, then hold valid and
  // payload until the handshake. Valid stays high into the next item unless
  // that item starts with an idle cycle.
  task automatic send_item(input action_e act, input logic signed [ValueWidth-1:0] val);
    in_t item;
    item.action = act;
    item.value  = val;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  initial begin
    int      kind;
    int      n_first;
    int      n_second;
    int      span;
    int      step_max;
    int      n_noise;
    bit      sorted_run;
    bit      pick_first;
    longint  cur_first;
    longint  cur_second;
    logic signed [ValueWidth-1:0] v;

    // Hold reset at the start, release it away from the clock edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    // Merge with both sequences empty: expect nothing.
    send_item(ACT_MERGE, 32'sh7FFF_FFFF);
    // Extremes on both sides, ties at the minimum and the maximum.
    send_item(ACT_FIRST,  32'sh8000_0000);
    send_item(ACT_SECOND, 32'sh8000_0000);
    send_item(ACT_FIRST,  -32'sd1);
    send_item(ACT_FIRST,  32'sd0);
    send_item(ACT_SECOND, 32'sd5);
    send_item(ACT_FIRST,  32'sh7FFF_FFFF);
    send_item(ACT_SECOND, 32'sh7FFF_FFFF);
    send_item(ACT_MERGE,  32'sd0);
    // Second sequence only, stored out of order.
    send_item(ACT_SECOND, 32'sd7);
    send_item(ACT_SECOND, -32'sd3);
    send_item(ACT_SECOND, 32'sd2);
    send_item(ACT_MERGE,  -32'sd1);
    // First sequence only, one entry.
    send_item(ACT_FIRST,  32'sd42);
    send_item(ACT_MERGE,  32'sh5555_5555);
    // Unused action around an equal pair.
    send_item(ACT_UNUSED, -32'sd1);
    send_item(ACT_FIRST,  32'sd100);
    send_item(ACT_UNUSED, 32'sd0);
    send_item(ACT_SECOND, 32'sd100);
    send_item(ACT_MERGE,  32'shAAAA_AAAA);

    // Random part: mostly load runs closed by a merge.
    while (items_sent < RandomItems) begin
      // Rotate the idling phase every 60 items.
      case ((items_sent / 60) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        sorted_run = (kind <= 5);
        if (kind == 5) begin
          // Fill toward or past DEPTH to exercise drops and long runs.
          n_first  = $urandom_range(DEPTH - 4, DEPTH + 3);
          n_second = $urandom_range(0, DEPTH + 3);
        end else if (sorted_run) begin
          n_first  = $urandom_range(0, 8);
          n_second = $urandom_range(0, 8);
        end else begin
          n_first  = $urandom_range(0, 6);
          n_second = $urandom_range(0, 6);
        end
        span = $urandom_range(0, 3);
        case (span)
          0: step_max = 2;
          1: step_max = 1000;
          2: step_max = 32'h0FFF_FFFF;
          default: step_max = 32'h7FFF_FFFF;
        endcase
        if (span == 3) cur_first = -64'sd2147483648 + $urandom_range(0, 16);
        else cur_first = $signed($urandom());
        // Share a start point half the time so that ties show up.
        if ($urandom_range(0, 1)) cur_second = cur_first;
        else cur_second = $signed($urandom());

        while (n_first > 0 || n_second > 0) begin
          pick_first = (n_second == 0) || (n_first > 0 && $urandom_range(0, 1));
          if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, $urandom());
          if (pick_first) begin
            v = sorted_run ? ValueWidth'(cur_first) : $urandom();
            send_item(ACT_FIRST, v);
            cur_first = cur_first + $urandom_range(0, step_max);
            if (cur_first > 64'sd2147483647) cur_first = 64'sd2147483647;
            n_first--;
          end else begin
            v = sorted_run ? ValueWidth'(cur_second) : $urandom();
            send_item(ACT_SECOND, v);
            cur_second = cur_second + $urandom_range(0, step_max);
            if (cur_second > 64'sd2147483647) cur_second = 64'sd2147483647;
            n_second--;
          end
        end
        send_item(ACT_MERGE, $urandom());
      end else begin
        // Noise: any code, any value; state carries into the next batch.
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_item(action_e'($urandom_range(0, 3)), $urandom());
      end
    end

    // Drop valid, drain every expected result, then let the block settle.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
